/* sv/potts_metropolis_site_update_assert.svh */
// assertion macros for the site updater top level
`ifndef POTTS_METROPOLIS_SITE_UPDATE_ASSERT_SVH
`define POTTS_METROPOLIS_SITE_UPDATE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Types and constants shared by the Potts Metropolis site updater.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pms_pkg;

    localparam int MAX_SIDE_DEF   = 128;
    localparam int MAX_LABELS_DEF = 8;

    localparam int LABEL_W   = 3;
    localparam int POS_OUT_W = 7;
    localparam int UNI_W     = 16;
    localparam int BETA_W    = 16;
    localparam int SIDE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // exp(-d) approximation constants
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] POLY_A    = 16'd43008;
    localparam logic [13:0] POLY_B    = 14'd10240;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_PREV_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_NEXT_ROW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_PREV_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_NEXT_COL = 3'd4;

    typedef struct packed {
        logic               kind;
        logic [LABEL_W-1:0] label;
        logic [UNI_W-1:0]   uniform;
    } in_item_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic [LABEL_W-1:0]   new_label;
        logic                 accepted;
        logic                 scan_end;
    } out_item_t;

    // which site a memory read refers to
    typedef enum logic [2:0] {
        SEL_CUR = 3'd0,
        SEL_UP  = 3'd1,
        SEL_DN  = 3'd2,
        SEL_LF  = 3'd3,
        SEL_RT  = 3'd4
    } site_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_EXP1,
        ST_EXP2,
        ST_EXP3,
        ST_EXP4,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      rd_en;
        site_sel_t rd_sel;
        logic      use_en;
        site_sel_t use_sel;
        logic      exp1;
        logic      exp2;
        logic      exp3;
        logic      exp4;
        logic      finish;
    } cmd_t;

    typedef struct packed {
        logic is_update;
        logic d_pos;
        logic out_free;
    } status_t;

endpackage

/* sv/potts_metropolis_site_update.sv */
// Sequence: a load goes from ST_READ to ST_WRITE; an update does five reads, ST_ACC,
// ST_EXP1, then ST_EXP2 to ST_EXP4 only if the energy change is positive, and ST_WRITE.
// Throughput: one transaction at a time, set by five sequential label memory
// reads on one read port and the four-step exponential unit.
// Reset: asynchronous active low; position returns to (0,0) and registers to
// defaults; label memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
// potts_metropolis_site_update
// Raster-order Metropolis updater of a square grid of Potts labels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "potts_metropolis_site_update_assert.svh"

module potts_metropolis_site_update #(
    parameter int MAX_SIDE   = pms_pkg::MAX_SIDE_DEF,
    parameter int MAX_LABELS = pms_pkg::MAX_LABELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pms_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pms_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pms_pkg::CFG_DAT_W-1:0] cfg_data
);

    pms_pkg::cmd_t    cmd;
    pms_pkg::status_t status;

    // sequencer
    pms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    pms_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_LABELS (MAX_LABELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // checks
    `PMS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")
    `PMS_ASSERT_IMPL(a_scan_end_diag, clk, rst_n, out_valid && out_data.scan_end, out_data.row == out_data.col, "scan end off diagonal")
    `PMS_ASSERT_IMPL(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result without transaction")

endmodule

/* sv/pms_ram.sv */
// ----------------------------------------------------------------------------
// pms_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pms_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pms_dp.sv */
// ----------------------------------------------------------------------------
// pms_dp
// Datapath: config registers, position, label memory, energy sum,
// exponential approximation and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pms_dp #(
    parameter int MAX_SIDE   = pms_pkg::MAX_SIDE_DEF,
    parameter int MAX_LABELS = pms_pkg::MAX_LABELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pms_pkg::cmd_t                        cmd,
    output pms_pkg::status_t                     status,
    input  pms_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pms_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pms_pkg::CFG_DAT_W-1:0]        cfg_data
);

    localparam int PW    = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (PW + 1 > pms_pkg::SIDE_W) ? PW + 1 : pms_pkg::SIDE_W;
    localparam int LW    = pms_pkg::LABEL_W;
    localparam int OW    = pms_pkg::POS_OUT_W;
    localparam int BW    = pms_pkg::BETA_W;

    // configuration registers
    logic [pms_pkg::SIDE_W-1:0] side_length_reg;
    logic [BW-1:0] beta_prev_row_reg, beta_next_row_reg;
    logic [BW-1:0] beta_prev_col_reg, beta_next_col_reg;

    // item and position state
    logic [PW-1:0] row_pos_reg, row_pos_next;
    logic [PW-1:0] col_pos_reg, col_pos_next;
    logic          kind_reg;
    logic [LW-1:0] lab_reg;
    logic [15:0]   uni_reg;
    logic [LW-1:0] cur_reg;
    logic signed [18:0] d_reg, d_next;
    logic [22:0]   t_reg;
    logic [31:0]   ff_reg;
    logic [15:0]   af_reg;
    logic [17:0]   m_reg;
    logic          exp_take_reg;
    logic          out_valid_reg;
    pms_pkg::out_item_t out_data_reg;

    // combinational helpers
    logic [SW-1:0] side_ext, side_eff;
    logic          pos_out;
    logic [LW-1:0] lab_fit;
    logic          has_up, has_dn, has_lf, has_rt;
    logic [AW-1:0] rd_addr, cur_addr;
    logic [LW-1:0] rdata;
    logic [BW-1:0] term_beta;
    logic          term_exists;
    logic          ne_cand, ne_cur;
    logic          d_pos, take;
    logic [34:0]   t_prod;
    logic [31:0]   a_prod;
    logic [45:0]   b_prod;
    logic [6:0]    exp_n;
    logic [15:0]   exp_f;
    logic [17:0]   p_val;
    logic          last_site;

    function automatic logic [AW-1:0] site_addr(input logic [PW-1:0] r, input logic [PW-1:0] c);
        site_addr = AW'(AW'(r) * AW'(MAX_SIDE) + AW'(c));
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_length_reg   <= pms_pkg::SIDE_W'(128);
            beta_prev_row_reg <= BW'(8192);
            beta_next_row_reg <= BW'(8192);
            beta_prev_col_reg <= BW'(8192);
            beta_next_col_reg <= BW'(8192);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pms_pkg::REG_SIDE_LENGTH:   side_length_reg   <= cfg_data[pms_pkg::SIDE_W-1:0];
                pms_pkg::REG_BETA_PREV_ROW: beta_prev_row_reg <= cfg_data;
                pms_pkg::REG_BETA_NEXT_ROW: beta_next_row_reg <= cfg_data;
                pms_pkg::REG_BETA_PREV_COL: beta_prev_col_reg <= cfg_data;
                pms_pkg::REG_BETA_NEXT_COL: beta_next_col_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp side and check position
    always_comb
    begin
        side_ext = SW'(side_length_reg);
        if (side_ext < SW'(2))
            side_eff = SW'(2);
        else if (side_ext > SW'(MAX_SIDE))
            side_eff = SW'(MAX_SIDE);
        else
            side_eff = side_ext;
        pos_out = (SW'(row_pos_reg) >= side_eff) || (SW'(col_pos_reg) >= side_eff);
    end

    // saturate incoming label
    always_comb
    begin
        if (9'(in_data.label) >= 9'(MAX_LABELS))
            lab_fit = LW'(MAX_LABELS - 1);
        else
            lab_fit = in_data.label;
    end

    // neighbor presence at the free boundary
    always_comb
    begin
        has_up = row_pos_reg != '0;
        has_dn = (SW'(row_pos_reg) + SW'(1)) < side_eff;
        has_lf = col_pos_reg != '0;
        has_rt = (SW'(col_pos_reg) + SW'(1)) < side_eff;
        last_site = (SW'(row_pos_reg) == side_eff - SW'(1))
                 && (SW'(col_pos_reg) == side_eff - SW'(1));
    end

    // read address select, absent neighbors read the current site
    always_comb
    begin
        cur_addr = site_addr(row_pos_reg, col_pos_reg);
        case (cmd.rd_sel)
            pms_pkg::SEL_UP:
                rd_addr = has_up ? site_addr(row_pos_reg - PW'(1), col_pos_reg) : cur_addr;
            pms_pkg::SEL_DN:
                rd_addr = has_dn ? site_addr(row_pos_reg + PW'(1), col_pos_reg) : cur_addr;
            pms_pkg::SEL_LF:
                rd_addr = has_lf ? site_addr(row_pos_reg, col_pos_reg - PW'(1)) : cur_addr;
            pms_pkg::SEL_RT:
                rd_addr = has_rt ? site_addr(row_pos_reg, col_pos_reg + PW'(1)) : cur_addr;
            default:
                rd_addr = cur_addr;
        endcase
    end

    // label memory
    pms_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.finish && take),
        .waddr (cur_addr),
        .wdata (lab_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // energy term for the neighbor whose data arrives now
    always_comb
    begin
        case (cmd.use_sel)
            pms_pkg::SEL_UP: begin term_beta = beta_prev_row_reg; term_exists = has_up; end
            pms_pkg::SEL_DN: begin term_beta = beta_next_row_reg; term_exists = has_dn; end
            pms_pkg::SEL_LF: begin term_beta = beta_prev_col_reg; term_exists = has_lf; end
            pms_pkg::SEL_RT: begin term_beta = beta_next_col_reg; term_exists = has_rt; end
            default:         begin term_beta = '0;                term_exists = 1'b0;   end
        endcase
        ne_cand = lab_reg != rdata;
        ne_cur  = cur_reg != rdata;
        d_next  = d_reg;
        if (term_exists && ne_cand && !ne_cur)
            d_next = d_reg + signed'(19'(term_beta));
        else if (term_exists && !ne_cand && ne_cur)
            d_next = d_reg - signed'(19'(term_beta));
    end

    // exponential approximation arithmetic
    always_comb
    begin
        t_prod = 35'(d_reg[17:0]) * 35'(pms_pkg::LOG2E_Q16);
        exp_n  = t_reg[22:16];
        exp_f  = t_reg[15:0];
        a_prod = 32'(exp_f) * 32'(pms_pkg::POLY_A);
        b_prod = 46'(ff_reg) * 46'(pms_pkg::POLY_B);
        if (exp_n >= 7'd17)
            p_val = '0;
        else
            p_val = m_reg >> exp_n[4:0];
        d_pos = !d_reg[18] && (d_reg != '0);
        take  = !kind_reg || !d_pos || exp_take_reg;
    end

    // next position after this site
    always_comb
    begin
        if ((SW'(col_pos_reg) + SW'(1)) < side_eff)
        begin
            col_pos_next = col_pos_reg + PW'(1);
            row_pos_next = row_pos_reg;
        end
        else
        begin
            col_pos_next = '0;
            row_pos_next = has_dn ? row_pos_reg + PW'(1) : '0;
        end
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && pos_out)
            begin
                row_pos_reg <= '0;
                col_pos_reg <= '0;
            end
            else if (cmd.finish)
            begin
                row_pos_reg <= row_pos_next;
                col_pos_reg <= col_pos_next;
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_data.kind;
            lab_reg  <= lab_fit;
            uni_reg  <= in_data.uniform;
            d_reg    <= '0;
        end
        else if (cmd.use_en)
        begin
            if (cmd.use_sel == pms_pkg::SEL_CUR)
                cur_reg <= rdata;
            else
                d_reg <= d_next;
        end
        if (cmd.exp1)
            t_reg <= t_prod[34:12];
        if (cmd.exp2)
        begin
            ff_reg <= 32'(exp_f) * 32'(exp_f);
            af_reg <= a_prod[31:16];
        end
        if (cmd.exp3)
            m_reg <= 18'(65536) - 18'(af_reg) + 18'(b_prod[45:32]);
        if (cmd.exp4)
            exp_take_reg <= 18'(uni_reg) < p_val;
        if (cmd.finish)
        begin
            out_data_reg.row       <= OW'(row_pos_reg);
            out_data_reg.col       <= OW'(col_pos_reg);
            out_data_reg.new_label <= take ? lab_reg : cur_reg;
            out_data_reg.accepted  <= take;
            out_data_reg.scan_end  <= last_site;
        end
    end

    assign status.is_update = kind_reg;
    assign status.d_pos     = d_pos;
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;

endmodule

/* sv/pms_ctrl.sv */
// ----------------------------------------------------------------------------
// pms_ctrl
// Controller: sequences reads, energy sum, exponential and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pms_pkg::status_t status,
    output pms_pkg::cmd_t    cmd
);

    pms_pkg::state_t state_reg, state_next;
    logic [2:0]      cnt_reg, cnt_next;

    // state and read counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pms_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = '0;
        case (state_reg)
            pms_pkg::ST_IDLE:
                if (in_valid)
                    state_next = pms_pkg::ST_READ;
            pms_pkg::ST_READ:
            begin
                if (!status.is_update)
                    state_next = pms_pkg::ST_WRITE;
                else if (cnt_reg == 3'(pms_pkg::SEL_RT))
                    state_next = pms_pkg::ST_ACC;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            pms_pkg::ST_ACC:
                state_next = pms_pkg::ST_EXP1;
            pms_pkg::ST_EXP1:
                state_next = status.d_pos ? pms_pkg::ST_EXP2 : pms_pkg::ST_WRITE;
            pms_pkg::ST_EXP2:
                state_next = pms_pkg::ST_EXP3;
            pms_pkg::ST_EXP3:
                state_next = pms_pkg::ST_EXP4;
            pms_pkg::ST_EXP4:
                state_next = pms_pkg::ST_WRITE;
            pms_pkg::ST_WRITE:
                if (status.out_free)
                    state_next = pms_pkg::ST_IDLE;
            default:
                state_next = pms_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd         = '0;
        cmd.rd_sel  = pms_pkg::site_sel_t'(cnt_reg);
        cmd.use_sel = pms_pkg::site_sel_t'(cnt_reg - 3'd1);
        in_stall    = state_reg != pms_pkg::ST_IDLE;
        case (state_reg)
            pms_pkg::ST_IDLE:  cmd.capture = in_valid;
            pms_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.use_en = cnt_reg != 3'(pms_pkg::SEL_CUR);
            end
            pms_pkg::ST_ACC:
            begin
                cmd.use_en  = 1'b1;
                cmd.use_sel = pms_pkg::SEL_RT;
            end
            pms_pkg::ST_EXP1:  cmd.exp1 = 1'b1;
            pms_pkg::ST_EXP2:  cmd.exp2 = 1'b1;
            pms_pkg::ST_EXP3:  cmd.exp3 = 1'b1;
            pms_pkg::ST_EXP4:  cmd.exp4 = 1'b1;
            pms_pkg::ST_WRITE: cmd.finish = status.out_free;
            default: ;
        endcase
    end

endmodule
